@@ rtl/ahum_pkg.sv @@
// Shared constants, pipeline stage types and constant helpers for the humidity converter.
`default_nettype none
package ahum_pkg;

  localparam logic signed [14:0] T_MIN   = -15'sd4000;
  localparam logic signed [14:0] T_MAX   = 15'sd12500;
  localparam logic [13:0]        RH_MAX  = 14'd10000;
  localparam logic signed [35:0] LN2_Q30 = 36'sd744261118;
  localparam logic [31:0]        Q30_ONE = 32'h4000_0000;
  localparam logic [23:0]        AH_SCALE = 24'd13244704;
  localparam logic [22:0]        OUT_MAX = 23'd2097151;
  localparam logic [32:0]        M1000   = 33'd4398046512;
  localparam int                 SH1000  = 42;

  localparam int XQ_BITS   = 33;
  localparam int QQ_BITS   = 40;
  localparam int HRN_STEPS = 9;
  localparam int LATENCY   = 2 + XQ_BITS + 3 + 2 * HRN_STEPS + 1 + QQ_BITS + 4;

  typedef struct packed {
    logic [21:0] rem;
    logic [32:0] quo;
    logic [21:0] den;
    logic [2:0]  mlo;
    logic        neg;
    logic [15:0] d2;
    logic [13:0] rh;
  } xdiv_t;

  typedef struct packed {
    logic [29:0]        f;
    logic [31:0]        acc;
    logic signed [4:0]  k;
    logic [15:0]        d2;
    logic [13:0]        rh;
  } hrn_t;

  typedef struct packed {
    logic [15:0]       rem;
    logic [39:0]       quo;
    logic [31:0]       plo;
    logic [15:0]       d2;
    logic signed [4:0] k;
  } qdiv_t;

  // Reciprocal for exact division of a 32-bit value by a small constant.
  function automatic logic [32:0] div_magic(input int j);
    logic [32:0] m;
    case (j)
      3:       m = 33'd5726623062;
      5:       m = 33'd6871947674;
      6:       m = 33'd5726623062;
      7:       m = 33'd4908534053;
      9:       m = 33'd7635497416;
      default: m = 33'h1_0000_0000;
    endcase
    return m;
  endfunction

  function automatic int div_shift(input int j);
    int s;
    case (j)
      1:       s = 32;
      2:       s = 33;
      3:       s = 34;
      4:       s = 34;
      9:       s = 36;
      default: s = 35;
    endcase
    return s;
  endfunction

  function automatic logic signed [35:0] kln2(input logic signed [4:0] k);
    return 36'(k) * LN2_Q30;
  endfunction

endpackage
`default_nettype wire

@@ rtl/absolute_humidity_from_rh.sv @@
// Top level of the absolute humidity converter: a fully pipelined Magnus formula datapath.
`default_nettype none
// The block turns a temperature in hundredths of a degree Celsius and a relative humidity in
// hundredths of a percent into absolute humidity in mg/m^3, truncated. Temperatures outside
// -40.00 to 125.00 degrees and humidities above 100.00 percent are saturated first. A
// transaction is accepted on every clock edge at which start is high; busy is never raised,
// so one conversion may enter in every cycle. Each result is marked by out_valid for one cycle,
// and results come out in the order the transactions went in. The pipeline is built mainly
// from two bit-per-stage restoring dividers (33 stages for the exponent argument, 40 for the
// final quotient) and a nine-step Horner evaluation of the exponential, two stages a step. The
// receiver cannot stall the block and the block holds no state between transactions.
module absolute_humidity_from_rh (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [14:0] in_temp_centi_c,
  input  wire logic [13:0]        in_rh_centi_pct,
  output logic                    out_valid,
  output logic [20:0]             out_abs_humidity_mg
);

  localparam int HN = 2 * ahum_pkg::HRN_STEPS;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Input stage: saturate the operands.
  logic signed [14:0] t0_r;
  logic [13:0]        r0_r;
  logic               v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (in_temp_centi_c < ahum_pkg::T_MIN) begin
      t0_r <= ahum_pkg::T_MIN;
    end else if (in_temp_centi_c > ahum_pkg::T_MAX) begin
      t0_r <= ahum_pkg::T_MAX;
    end else begin
      t0_r <= in_temp_centi_c;
    end
    r0_r <= (in_rh_centi_pct > ahum_pkg::RH_MAX) ? ahum_pkg::RH_MAX : in_rh_centi_pct;
  end

  // Preparation stage: the exponent argument is 1762*t*2^30 / (100*(24312+t)), formed on the
  // magnitude of t with the sign carried alongside. The divisor of the final quotient,
  // 27315+t, is formed here as well.
  ahum_pkg::xdiv_t xd_r [0:ahum_pkg::XQ_BITS];
  logic            xv_r [0:ahum_pkg::XQ_BITS];
  ahum_pkg::xdiv_t xprep;

  always_comb begin
    logic [14:0] tabs;
    logic [24:0] mag;
    logic signed [16:0] tsum;
    logic [15:0] tsu;
    logic [22:0] den;
    logic signed [16:0] d2s;
    tabs = t0_r[14] ? 15'(-t0_r) : 15'(t0_r);
    mag  = 25'(tabs) * 25'd1762;
    tsum = 17'sd24312 + 17'(t0_r);
    tsu  = tsum[15:0];
    den  = 23'(tsu) * 23'd100;
    d2s  = 17'sd27315 + 17'(t0_r);
    xprep.rem = mag[24:3];
    xprep.quo = '0;
    xprep.den = den[21:0];
    xprep.mlo = mag[2:0];
    xprep.neg = t0_r[14];
    xprep.d2  = d2s[15:0];
    xprep.rh  = r0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xv_r[0] <= 1'b0;
    end else begin
      xv_r[0] <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    xd_r[0] <= xprep;
  end

  // Exponent argument divider: one quotient bit per stage, most significant first.
  for (genvar i = 0; i < ahum_pkg::XQ_BITS; i++) begin : g_xdiv
    localparam int B = ahum_pkg::XQ_BITS - 1 - i;
    logic            inbit;
    logic [22:0]     trial;
    logic            ge;
    ahum_pkg::xdiv_t nxt;

    if (B >= 30) begin : g_bit
      assign inbit = xd_r[i].mlo[B - 30];
    end else begin : g_zero
      assign inbit = 1'b0;
    end

    always_comb begin
      trial   = {xd_r[i].rem, inbit};
      ge      = trial >= {1'b0, xd_r[i].den};
      nxt     = xd_r[i];
      nxt.rem = ge ? 22'(trial - {1'b0, xd_r[i].den}) : trial[21:0];
      nxt.quo = {xd_r[i].quo[31:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        xv_r[i+1] <= 1'b0;
      end else begin
        xv_r[i+1] <= xv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      xd_r[i+1] <= nxt;
    end
  end

  // Sign restore, then split x = k*ln2 + f with k = floor(x / ln2).
  logic signed [35:0] x_r;
  logic [15:0]        xd2_r;
  logic [13:0]        xrh_r;
  logic               xsv_r;
  logic signed [35:0] kx_r;
  logic signed [4:0]  k_r;
  logic [15:0]        kd2_r;
  logic [13:0]        krh_r;
  logic               kv_r;
  logic signed [4:0]  kk;

  always_comb begin
    kk = -5'sd8;
    for (int j = -7; j <= 9; j++) begin
      if (x_r >= ahum_pkg::kln2(5'(j))) begin
        kk = 5'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xsv_r <= 1'b0;
      kv_r  <= 1'b0;
    end else begin
      xsv_r <= xv_r[ahum_pkg::XQ_BITS];
      kv_r  <= xsv_r;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= xd_r[ahum_pkg::XQ_BITS].neg ? -$signed({3'b000, xd_r[ahum_pkg::XQ_BITS].quo})
                                          : $signed({3'b000, xd_r[ahum_pkg::XQ_BITS].quo});
    xd2_r <= xd_r[ahum_pkg::XQ_BITS].d2;
    xrh_r <= xd_r[ahum_pkg::XQ_BITS].rh;
    kx_r  <= x_r;
    k_r   <= kk;
    kd2_r <= xd2_r;
    krh_r <= xrh_r;
  end

  // Fraction stage: f lies in [0, ln2) and seeds the Horner chain with p = 1.
  ahum_pkg::hrn_t hr_r [0:HN];
  logic           hv_r [0:HN];
  ahum_pkg::hrn_t hseed;

  always_comb begin
    logic signed [35:0] fd;
    fd        = kx_r - ahum_pkg::kln2(k_r);
    hseed.f   = fd[29:0];
    hseed.acc = ahum_pkg::Q30_ONE;
    hseed.k   = k_r;
    hseed.d2  = kd2_r;
    hseed.rh  = krh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r[0] <= 1'b0;
    end else begin
      hv_r[0] <= kv_r;
    end
  end

  always_ff @(posedge clk) begin
    hr_r[0] <= hseed;
  end

  // Horner evaluation of exp(f): p = 1 + (f*p >> 30) / j for j = 9 down to 1. The first stage
  // of a step multiplies, the second divides by j through an exact reciprocal and adds one.
  for (genvar i = 0; i < ahum_pkg::HRN_STEPS; i++) begin : g_hrn
    localparam int          J  = ahum_pkg::HRN_STEPS - i;
    localparam int          SH = ahum_pkg::div_shift(J);
    localparam logic [32:0] MG = ahum_pkg::div_magic(J);
    logic [61:0]    fp;
    logic [67:0]    yq;
    ahum_pkg::hrn_t na;
    ahum_pkg::hrn_t nb;

    always_comb begin
      fp     = 62'(hr_r[2*i].f) * 62'(hr_r[2*i].acc);
      na     = hr_r[2*i];
      na.acc = fp[61:30];
      yq     = 68'(hr_r[2*i+1].acc) * 68'(MG);
      nb     = hr_r[2*i+1];
      nb.acc = ahum_pkg::Q30_ONE + yq[SH +: 32];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hv_r[2*i+1] <= 1'b0;
        hv_r[2*i+2] <= 1'b0;
      end else begin
        hv_r[2*i+1] <= hv_r[2*i];
        hv_r[2*i+2] <= hv_r[2*i+1];
      end
    end

    always_ff @(posedge clk) begin
      hr_r[2*i+1] <= na;
      hr_r[2*i+2] <= nb;
    end
  end

  // Product stage: p*r, whose value shifted left by 8 is divided by 27315+t.
  ahum_pkg::qdiv_t qd_r [0:ahum_pkg::QQ_BITS];
  logic            qv_r [0:ahum_pkg::QQ_BITS];
  ahum_pkg::qdiv_t qseed;

  always_comb begin
    logic [45:0] pr;
    pr        = 46'(hr_r[HN].acc) * 46'(hr_r[HN].rh);
    qseed.rem = {2'b00, pr[45:32]};
    qseed.quo = '0;
    qseed.plo = pr[31:0];
    qseed.d2  = hr_r[HN].d2;
    qseed.k   = hr_r[HN].k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r[0] <= 1'b0;
    end else begin
      qv_r[0] <= hv_r[HN];
    end
  end

  always_ff @(posedge clk) begin
    qd_r[0] <= qseed;
  end

  // Final quotient divider: one bit per stage, giving q in Q38.
  for (genvar i = 0; i < ahum_pkg::QQ_BITS; i++) begin : g_qdiv
    localparam int B = ahum_pkg::QQ_BITS - 1 - i;
    logic            inbit;
    logic [16:0]     trial;
    logic            ge;
    ahum_pkg::qdiv_t nxt;

    if (B >= 8) begin : g_bit
      assign inbit = qd_r[i].plo[B - 8];
    end else begin : g_zero
      assign inbit = 1'b0;
    end

    always_comb begin
      trial   = {qd_r[i].rem, inbit};
      ge      = trial >= {1'b0, qd_r[i].d2};
      nxt     = qd_r[i];
      nxt.rem = ge ? 16'(trial - {1'b0, qd_r[i].d2}) : trial[15:0];
      nxt.quo = {qd_r[i].quo[38:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qv_r[i+1] <= 1'b0;
      end else begin
        qv_r[i+1] <= qv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      qd_r[i+1] <= nxt;
    end
  end

  // Scaling: v = q*13244704, then v >> (38-k), then an exact divide by 1000.
  logic [63:0] v_r;
  logic [5:0]  s_r;
  logic        vv_r;
  logic [31:0] w_r;
  logic        wv_r;
  logic [22:0] z_r;
  logic        zv_r;
  logic signed [6:0] sfull;
  logic [63:0] vsh;
  logic [64:0] wm;

  assign sfull = 7'sd38 - 7'(qd_r[ahum_pkg::QQ_BITS].k);
  assign vsh   = v_r >> s_r;
  assign wm    = 65'(w_r) * 65'(ahum_pkg::M1000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vv_r      <= 1'b0;
      wv_r      <= 1'b0;
      zv_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vv_r      <= qv_r[ahum_pkg::QQ_BITS];
      wv_r      <= vv_r;
      zv_r      <= wv_r;
      out_valid <= zv_r;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= 64'(qd_r[ahum_pkg::QQ_BITS].quo) * 64'(ahum_pkg::AH_SCALE);
    s_r <= sfull[5:0];
    w_r <= vsh[31:0];
    z_r <= wm[ahum_pkg::SH1000 +: 23];
    out_abs_humidity_mg <= (z_r > ahum_pkg::OUT_MAX) ? ahum_pkg::OUT_MAX[20:0] : z_r[20:0];
  end

  // Every accepted transaction leaves exactly one result, after the fixed latency.
  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(ahum_pkg::LATENCY) out_valid)
    else $error("accepted transaction produced no result");

  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##(ahum_pkg::LATENCY) !out_valid)
    else $error("result without a transaction");

  a_xdiv_rem : assert property (@(posedge clk) disable iff (!rst_n)
    xv_r[ahum_pkg::XQ_BITS] |->
      xd_r[ahum_pkg::XQ_BITS].rem < xd_r[ahum_pkg::XQ_BITS].den)
    else $error("exponent divider remainder not below divisor");

  a_frac_range : assert property (@(posedge clk) disable iff (!rst_n)
    hv_r[0] |-> $signed({6'b0, hr_r[0].f}) < ahum_pkg::LN2_Q30)
    else $error("exponent fraction outside [0, ln2)");

  a_exp_floor : assert property (@(posedge clk) disable iff (!rst_n)
    hv_r[HN] |-> hr_r[HN].acc >= ahum_pkg::Q30_ONE)
    else $error("exponential below one");

endmodule
`default_nettype wire

@@ sim/tb_absolute_humidity_from_rh.sv @@
// Self-checking testbench for the Magnus formula absolute humidity converter.
`default_nettype none
module tb_absolute_humidity_from_rh;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [14:0] in_temp_centi_c = '0;
  logic [13:0]        in_rh_centi_pct = '0;
  logic               out_valid;
  logic [20:0]        out_abs_humidity_mg;

  typedef struct packed {
    logic signed [14:0] temp;
    logic [13:0]        rh;
  } sample_t;

  sample_t     pending_samples[$];
  logic [20:0] expected_humidity[$];
  int          error_count = 0;
  int          samples_sent = 0;
  int          results_seen = 0;
  longint      cycle_count = 0;
  logic        pause_for_drain = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;

  absolute_humidity_from_rh i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_temp_centi_c     (in_temp_centi_c),
    .in_rh_centi_pct     (in_rh_centi_pct),
    .out_valid           (out_valid),
    .out_abs_humidity_mg (out_abs_humidity_mg)
  );

  always #5 clk = ~clk;

  // Fixed-point prediction of one conversion. Inputs are saturated first, then the exponent
  // argument is formed in Q30, split into a power of two and a fraction, and the fraction's
  // exponential is found by a nine-step Horner sum before the final quotient and scaling.
  function automatic logic [20:0] predict_humidity(input logic signed [14:0] temp_in,
                                                   input logic [13:0] rh_in);
    longint          t;
    longint unsigned r, mag, den, q, f, p, v, res;
    longint          x, k;
    int              j;
    t = temp_in;
    r = rh_in;
    if (t < -4000) t = -4000;
    if (t > 12500) t = 12500;
    if (r > 10000) r = 10000;
    mag = (t < 0) ? -1762 * t : 1762 * t;
    den = 100 * (24312 + t);
    q = (mag << 30) / den;
    x = (t < 0) ? -longint'(q) : longint'(q);
    if (x >= 0) k = x / 744261118;
    else        k = -((-x + 744261118 - 1) / 744261118);
    f = x - k * 744261118;
    p = 64'd1 << 30;
    for (j = 9; j >= 1; j--)
      p = (64'd1 << 30) + ((f * p) >> 30) / j;
    q = ((p * r) << 8) / (27315 + t);
    v = q * 64'd13244704;
    res = (v >> (38 - k)) / 1000;
    if (res > 2097151) res = 2097151;
    return res[20:0];
  endfunction

  // Driver: feeds queued samples in bursts separated by random gaps. A transaction is taken
  // at an edge where start is high and busy is low; the prediction is recorded at that edge.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (start && !busy) begin
        expected_humidity.push_back(predict_humidity(in_temp_centi_c, in_rh_centi_pct));
        samples_sent <= samples_sent + 1;
      end
      if (start && busy) begin
        // The offered transaction stays on the ports until the block takes it.
      end else if (pause_for_drain || pending_samples.size() == 0) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else begin
        sample_t s;
        s = pending_samples.pop_front();
        in_temp_centi_c <= s.temp;
        in_rh_centi_pct <= s.rh;
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Monitor: the block cannot be stalled, so every strobe is a result to be checked.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (expected_humidity.size() == 0) begin
        $display("%0t: unexpected result %0d", $time, out_abs_humidity_mg);
        error_count <= error_count + 1;
      end else begin
        logic [20:0] want;
        want = expected_humidity.pop_front();
        if (out_abs_humidity_mg !== want) begin
          $display("%0t: humidity mismatch: expected %0d, actual %0d",
                   $time, want, out_abs_humidity_mg);
          error_count <= error_count + 1;
        end
      end
    end
  end

  // Generous limit on the whole run.
  always @(posedge clk) begin
    if (cycle_count > 200000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_absolute_humidity_from_rh: errors");
      $finish;
    end
  end

  function automatic sample_t make_sample(input int temp, input int rh);
    sample_t s;
    s.temp = temp[14:0];
    s.rh = rh[13:0];
    return s;
  endfunction

  initial begin
    int i;
    int mode;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed samples: the range limits, values beyond them that saturate, zero humidity,
    // the freezing point and the extremes of each field's encoding.
    pending_samples.push_back(make_sample(-4000, 0));
    pending_samples.push_back(make_sample(-4000, 10000));
    pending_samples.push_back(make_sample(12500, 10000));
    pending_samples.push_back(make_sample(12500, 0));
    pending_samples.push_back(make_sample(0, 10000));
    pending_samples.push_back(make_sample(0, 5000));
    pending_samples.push_back(make_sample(-1, 1));
    pending_samples.push_back(make_sample(1, 1));
    pending_samples.push_back(make_sample(2500, 5000));
    pending_samples.push_back(make_sample(-16384, 16383));
    pending_samples.push_back(make_sample(16383, 16383));
    pending_samples.push_back(make_sample(-4001, 10001));
    pending_samples.push_back(make_sample(12501, 12000));
    pending_samples.push_back(make_sample(-2000, 9999));
    pending_samples.push_back(make_sample(8000, 7777));
    pending_samples.push_back(make_sample(-21, 8191));
    pending_samples.push_back(make_sample(4095, 4096));
    wait (pending_samples.size() == 0 && !start);

    // Hold the sender off until every directed result has come back.
    pause_for_drain <= 1'b1;
    wait (samples_sent == results_seen && expected_humidity.size() == 0);
    @(posedge clk);
    pause_for_drain <= 1'b0;

    // Random samples: mostly inside the sensor range, some across the whole encoding.
    for (i = 0; i < 1250; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 7)
        pending_samples.push_back(make_sample($urandom_range(0, 16500) - 4000,
                                              $urandom_range(0, 10000)));
      else if (mode < 9)
        pending_samples.push_back(make_sample($urandom_range(0, 32767) - 16384,
                                              $urandom_range(0, 16383)));
      else
        pending_samples.push_back(make_sample($urandom_range(0, 1) ? 12500 : -4000,
                                              $urandom_range(9990, 16383)));
    end
    wait (pending_samples.size() == 0 && !start);
    wait (expected_humidity.size() == 0);
    repeat (ahum_pkg::LATENCY + 20) @(posedge clk);

    $display("Checked %0d conversions over the sensor range, saturation cases",
             results_seen);
    $display("and full input encodings, with bursty traffic and a drain pause.");
    if (error_count == 0 && expected_humidity.size() == 0) begin
      $display("tb_absolute_humidity_from_rh: clean");
    end else begin
      $display("tb_absolute_humidity_from_rh: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
